FILE: rtl/sot_pkg.sv
// shape overlap tester package: command codes, register indexes and reset values
// no dependencies; imported by shape_overlap_tester

package sot_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int SIZE_BITS          = 15;
    localparam int CMD_BITS           = 3;
    localparam int CFG_INDEX_BITS     = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_BOX_BOX       = 3'd0,
        CMD_POINT_BOX     = 3'd1,
        CMD_POINT_CIRCLE  = 3'd2,
        CMD_CIRCLE_CIRCLE = 3'd3,
        CMD_CIRCLE_BOX    = 3'd4,
        CMD_BOX_WINDOW    = 3'd5
    } cmd_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_TOP    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_HEIGHT = 2'd3;

    localparam logic [SIZE_BITS-1:0] WINDOW_WIDTH_RESET  = 15'd800;
    localparam logic [SIZE_BITS-1:0] WINDOW_HEIGHT_RESET = 15'd600;

endpackage

FILE: rtl/shape_overlap_tester.sv
// shape overlap tester: box, point and circle overlap questions, one hit flag per item
// depends on sot_pkg for command codes, register indexes and reset values
// 5 register stages: input, edge tests, magnitudes, squares, compare and result
// throughput: one item per cycle unless out_ready stalls; circle corner squares set depth
// stages advance independently, so an item is taken whenever the input stage frees up
// reset clears all stage valid bits and returns the window to left 0, top 0, 800 by 600
// payload registers are not reset

module shape_overlap_tester #(
    parameter int COORD_BITS = sot_pkg::COORD_BITS_DEFAULT,
    localparam int CFG_BITS  = (COORD_BITS > sot_pkg::SIZE_BITS) ? COORD_BITS
                                                                 : sot_pkg::SIZE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sot_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sot_pkg::CMD_BITS-1:0]        command,
    input  logic signed [COORD_BITS-1:0]        first_x,
    input  logic signed [COORD_BITS-1:0]        first_y,
    input  logic [sot_pkg::SIZE_BITS-1:0]       first_w,
    input  logic [sot_pkg::SIZE_BITS-1:0]       first_h,
    input  logic [sot_pkg::SIZE_BITS-1:0]       first_radius,
    input  logic signed [COORD_BITS-1:0]        second_x,
    input  logic signed [COORD_BITS-1:0]        second_y,
    input  logic [sot_pkg::SIZE_BITS-1:0]       second_w,
    input  logic [sot_pkg::SIZE_BITS-1:0]       second_h,
    input  logic [sot_pkg::SIZE_BITS-1:0]       second_radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit
);

    import sot_pkg::*;

    localparam int STAGES = 5;
    localparam int LAST   = STAGES - 1;
    // working width for coordinate plus size sums and their differences
    localparam int WB     = ((COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1) + 2;
    // radius of a circle pair reaches twice the size range
    localparam int RB     = SIZE_BITS + 1;
    localparam int SQB    = 2 * RB;

    // ---------------- configuration ----------------
    logic signed [COORD_BITS-1:0] win_left_reg;
    logic signed [COORD_BITS-1:0] win_top_reg;
    logic [SIZE_BITS-1:0]         win_width_reg;
    logic [SIZE_BITS-1:0]         win_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_width_reg  <= WINDOW_WIDTH_RESET;
            win_height_reg <= WINDOW_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEFT:   win_left_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_WINDOW_TOP:    win_top_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_WINDOW_WIDTH:  win_width_reg  <= cfg_data[SIZE_BITS-1:0];
                CFG_WINDOW_HEIGHT: win_height_reg <= cfg_data[SIZE_BITS-1:0];
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] move;

    always_comb
    begin
        move[LAST] = valid_reg[LAST] & out_ready;
        load[LAST] = ~valid_reg[LAST] | move[LAST];
        for (int i = LAST - 1; i >= 0; i--)
        begin
            move[i] = valid_reg[i] & load[i+1];
            load[i] = ~valid_reg[i] | move[i];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[LAST];

    // ---------------- stage 0: input register ----------------
    logic [CMD_BITS-1:0]          cmd_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [SIZE_BITS-1:0]         aw_reg, ah_reg, ar_reg, bw_reg, bh_reg, br_reg;

    always_ff @(posedge clk)
    begin
        if (load[0] && in_valid)
        begin
            cmd_reg <= command;
            ax_reg  <= first_x;
            ay_reg  <= first_y;
            aw_reg  <= first_w;
            ah_reg  <= first_h;
            ar_reg  <= first_radius;
            bx_reg  <= second_x;
            by_reg  <= second_y;
            bw_reg  <= second_w;
            bh_reg  <= second_h;
            br_reg  <= second_radius;
        end
    end

    // ---------------- stage 1: edge tests and corner differences ----------------
    logic signed [WB-1:0] ax_w, ay_w, aw_w, ah_w, ar_w, bx_w, by_w, bw_w, bh_w;
    logic signed [WB-1:0] wl_w, wt_w, ww_w, wh_w;
    logic signed [WB-1:0] a_right, a_bottom, b_right, b_bottom, win_right, win_bottom;
    logic signed [WB-1:0] c_left, c_right, c_top, c_bottom;
    logic                 bbox_ok, pt_in_b, proj_x, proj_y;

    assign ax_w = WB'(ax_reg);
    assign ay_w = WB'(ay_reg);
    assign bx_w = WB'(bx_reg);
    assign by_w = WB'(by_reg);
    assign wl_w = WB'(win_left_reg);
    assign wt_w = WB'(win_top_reg);
    assign aw_w = WB'($signed({1'b0, aw_reg}));
    assign ah_w = WB'($signed({1'b0, ah_reg}));
    assign ar_w = WB'($signed({1'b0, ar_reg}));
    assign bw_w = WB'($signed({1'b0, bw_reg}));
    assign bh_w = WB'($signed({1'b0, bh_reg}));
    assign ww_w = WB'($signed({1'b0, win_width_reg}));
    assign wh_w = WB'($signed({1'b0, win_height_reg}));

    assign a_right    = ax_w + aw_w;
    assign a_bottom   = ay_w + ah_w;
    assign b_right    = bx_w + bw_w;
    assign b_bottom   = by_w + bh_w;
    assign win_right  = wl_w + ww_w;
    assign win_bottom = wt_w + wh_w;
    assign c_left     = ax_w - ar_w;
    assign c_right    = ax_w + ar_w;
    assign c_top      = ay_w - ar_w;
    assign c_bottom   = ay_w + ar_w;

    // bounding box of the first circle against the second box
    assign bbox_ok = !(c_left >= b_right || c_right <= bx_w ||
                       c_top >= b_bottom || c_bottom <= by_w);
    assign pt_in_b = ax_w >= bx_w && ax_w < b_right && ay_w >= by_w && ay_w < b_bottom;
    // the dot product signs reduce to the centre lying within the edge span
    assign proj_y  = (bh_reg == '0) || (ay_w >= by_w && ay_w <= b_bottom);
    assign proj_x  = (bw_reg == '0) || (ax_w >= bx_w && ax_w <= b_right);

    logic signed [WB-1:0] cx, cy, x0, x1, y0, y1;
    logic [RB-1:0]        r_a_next;
    logic                 fixed_a_next;
    logic [3:0]           mask_a_next;

    always_comb
    begin
        fixed_a_next = 1'b0;
        mask_a_next  = 4'b0000;
        cx = bx_w;
        cy = by_w;
        x0 = ax_w;
        x1 = ax_w;
        y0 = ay_w;
        y1 = ay_w;
        r_a_next = RB'(br_reg);
        case (cmd_t'(cmd_reg))
            CMD_BOX_BOX:
            begin
                fixed_a_next = bx_w < a_right && b_right > ax_w &&
                               by_w < a_bottom && b_bottom > ay_w;
            end
            CMD_POINT_BOX:
            begin
                fixed_a_next = pt_in_b;
            end
            CMD_POINT_CIRCLE:
            begin
                mask_a_next = 4'b0001;
            end
            CMD_CIRCLE_CIRCLE:
            begin
                mask_a_next = 4'b0001;
                r_a_next    = RB'(ar_reg) + RB'(br_reg);
            end
            CMD_CIRCLE_BOX:
            begin
                cx = ax_w;
                cy = ay_w;
                x0 = bx_w;
                x1 = b_right;
                y0 = by_w;
                y1 = b_bottom;
                r_a_next     = RB'(ar_reg);
                fixed_a_next = bbox_ok && (pt_in_b || proj_y || proj_x);
                mask_a_next  = bbox_ok ? 4'b1111 : 4'b0000;
            end
            CMD_BOX_WINDOW:
            begin
                fixed_a_next = ax_w < wl_w || a_right > win_right ||
                               ay_w < wt_w || a_bottom > win_bottom;
            end
            default:
            begin
                fixed_a_next = 1'b0;
            end
        endcase
    end

    logic signed [WB-1:0] dx0_a_reg, dx1_a_reg, dy0_a_reg, dy1_a_reg;
    logic [RB-1:0]        r_a_reg;
    logic                 fixed_a_reg;
    logic [3:0]           mask_a_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            dx0_a_reg   <= x0 - cx;
            dx1_a_reg   <= x1 - cx;
            dy0_a_reg   <= y0 - cy;
            dy1_a_reg   <= y1 - cy;
            r_a_reg     <= r_a_next;
            fixed_a_reg <= fixed_a_next;
            mask_a_reg  <= mask_a_next;
        end
    end

    // ---------------- stage 2: magnitudes against the radius ----------------
    function automatic logic [WB-1:0] magnitude(input logic signed [WB-1:0] d);
        logic [WB-1:0] m;
        m = d[WB-1] ? WB'(-d) : WB'(d);
        return m;
    endfunction

    logic [WB-1:0] mx0, mx1, my0, my1;
    logic [WB-1:0] r_wide;

    assign mx0    = magnitude(dx0_a_reg);
    assign mx1    = magnitude(dx1_a_reg);
    assign my0    = magnitude(dy0_a_reg);
    assign my1    = magnitude(dy1_a_reg);
    assign r_wide = WB'(r_a_reg);

    logic [RB-1:0] mx0_b_reg, mx1_b_reg, my0_b_reg, my1_b_reg, r_b_reg;
    logic [1:0]    near_x_b_reg, near_y_b_reg;
    logic          fixed_b_reg;
    logic [3:0]    mask_b_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            // a far magnitude is cut short here, its near flag keeps it out
            mx0_b_reg    <= mx0[RB-1:0];
            mx1_b_reg    <= mx1[RB-1:0];
            my0_b_reg    <= my0[RB-1:0];
            my1_b_reg    <= my1[RB-1:0];
            near_x_b_reg <= {mx1 <= r_wide, mx0 <= r_wide};
            near_y_b_reg <= {my1 <= r_wide, my0 <= r_wide};
            r_b_reg      <= r_a_reg;
            fixed_b_reg  <= fixed_a_reg;
            mask_b_reg   <= mask_a_reg;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic [SQB-1:0] sqx0_c_reg, sqx1_c_reg, sqy0_c_reg, sqy1_c_reg, rr_c_reg;
    logic [3:0]     cand_c_reg;
    logic           fixed_c_reg;
    logic [3:0]     near_corner;

    // corner order: (x0,y0) (x0,y1) (x1,y0) (x1,y1)
    assign near_corner = {near_x_b_reg[1] & near_y_b_reg[1], near_x_b_reg[1] & near_y_b_reg[0],
                          near_x_b_reg[0] & near_y_b_reg[1], near_x_b_reg[0] & near_y_b_reg[0]};

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            sqx0_c_reg  <= SQB'(mx0_b_reg) * SQB'(mx0_b_reg);
            sqx1_c_reg  <= SQB'(mx1_b_reg) * SQB'(mx1_b_reg);
            sqy0_c_reg  <= SQB'(my0_b_reg) * SQB'(my0_b_reg);
            sqy1_c_reg  <= SQB'(my1_b_reg) * SQB'(my1_b_reg);
            rr_c_reg    <= SQB'(r_b_reg) * SQB'(r_b_reg);
            cand_c_reg  <= mask_b_reg & near_corner;
            fixed_c_reg <= fixed_b_reg;
        end
    end

    // ---------------- stage 4: distance compare and result ----------------
    logic [SQB:0] rr_wide;
    logic [3:0]   in_circle;
    logic         hit_reg;

    assign rr_wide      = (SQB+1)'(rr_c_reg);
    assign in_circle[0] = ((SQB+1)'(sqx0_c_reg) + (SQB+1)'(sqy0_c_reg)) <= rr_wide;
    assign in_circle[1] = ((SQB+1)'(sqx0_c_reg) + (SQB+1)'(sqy1_c_reg)) <= rr_wide;
    assign in_circle[2] = ((SQB+1)'(sqx1_c_reg) + (SQB+1)'(sqy0_c_reg)) <= rr_wide;
    assign in_circle[3] = ((SQB+1)'(sqx1_c_reg) + (SQB+1)'(sqy1_c_reg)) <= rr_wide;

    always_ff @(posedge clk)
    begin
        if (load[LAST])
        begin
            hit_reg <= fixed_c_reg | (|(cand_c_reg & in_circle));
        end
    end

    assign hit = hit_reg;

`ifndef SYNTHESIS
    // an empty input stage always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> in_ready)
        else $error("input stage empty but not ready");

    // with the consumer ready, an item in the square stage reaches the output next cycle
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST-1] && out_ready) |=> out_valid)
        else $error("item stalled with the consumer ready");

    // unused command codes never raise a hit or a corner test
    a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && load[1] && (cmd_reg > CMD_BOX_WINDOW))
        |=> (!fixed_a_reg && mask_a_reg == 4'b0000))
        else $error("unused command produced a hit path");

    // corner tests are either the single point or all four box corners
    a_corner_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && mask_a_reg != 4'b0000)
        |-> (mask_a_reg == 4'b0001 || mask_a_reg == 4'b1111))
        else $error("bad corner mask");
`endif

endmodule
